FILE: hw/rtl/apd_pkg.sv
// Shared types and constants for the arm pose hold detector.
// Used by apd_delta, apd_window and the top level; depends on nothing.
package apd_pkg;

  localparam int unsigned PIX_W    = 10;
  localparam int unsigned DELTA_W  = 11;
  localparam int unsigned DEPTH_W  = 13;
  localparam int unsigned HOLD_W   = 8;
  localparam int unsigned WINDOW_DEF = 20;

  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // Register reset values.
  localparam logic [PIX_W-1:0]   RST_HE_DX_MAX = 10'd50;
  localparam logic [DELTA_W-1:0] RST_HE_DY_MIN = 11'd20;
  localparam logic [DELTA_W-1:0] RST_ES_DY_MAX = 11'd60;
  localparam logic [DELTA_W-1:0] RST_ES_DX_MIN = 11'd30;
  localparam logic [DEPTH_W-1:0] RST_DEPTH_MIN = 13'd700;
  localparam logic [HOLD_W-1:0]  RST_HOLD      = 8'd15;

  typedef enum logic [2:0] {
    REG_HE_DX_MAX = 3'd0,
    REG_HE_DY_MIN = 3'd1,
    REG_ES_DY_MAX = 3'd2,
    REG_ES_DX_MIN = 3'd3,
    REG_DEPTH_MIN = 3'd4,
    REG_HOLD      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0]          he_dx_max;
    logic signed [DELTA_W-1:0] he_dy_min;
    logic signed [DELTA_W-1:0] es_dy_max;
    logic signed [DELTA_W-1:0] es_dx_min;
    logic [DEPTH_W-1:0]        depth_min;
    logic [HOLD_W-1:0]         hold_frames;
  } cfg_t;

  // One frame after the delta stage.
  typedef struct packed {
    logic                      joints_valid;
    logic                      depth_ok;
    logic signed [DELTA_W-1:0] he_dx;   // |hand_x - elbow_x|
    logic signed [DELTA_W-1:0] he_dy;   // hand_y - elbow_y
    logic signed [DELTA_W-1:0] es_dy;   // elbow_y - shoulder_y
    logic signed [DELTA_W-1:0] se_dx;   // shoulder_x - elbow_x
  } frame_t;

endpackage

FILE: hw/rtl/apd_delta.sv
// Input stage of the arm pose hold detector: registers the four joint deltas
// and the depth check of each accepted frame. Depends on apd_pkg.
module apd_delta (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         joints_valid,
  input  logic [apd_pkg::PIX_W-1:0]    shoulder_x,
  input  logic [apd_pkg::PIX_W-1:0]    shoulder_y,
  input  logic [apd_pkg::PIX_W-1:0]    elbow_x,
  input  logic [apd_pkg::PIX_W-1:0]    elbow_y,
  input  logic [apd_pkg::PIX_W-1:0]    hand_x,
  input  logic [apd_pkg::PIX_W-1:0]    hand_y,
  input  logic [apd_pkg::DEPTH_W-1:0]  hand_depth,
  input  logic [apd_pkg::DEPTH_W-1:0]  depth_min,
  input  logic                         down_ready,
  output logic                         frm_valid,
  output apd_pkg::frame_t              frm
);
  import apd_pkg::*;

  logic                      valid_r, valid_nxt;
  frame_t                    frm_r, frm_nxt;
  logic signed [DELTA_W-1:0] hx_diff;
  logic                      in_fire;

  assign in_ready = !valid_r || down_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    hx_diff              = $signed({1'b0, hand_x}) - $signed({1'b0, elbow_x});
    frm_nxt.joints_valid = joints_valid;
    frm_nxt.depth_ok     = hand_depth > depth_min;
    frm_nxt.he_dx        = hx_diff[DELTA_W-1] ? -hx_diff : hx_diff;
    frm_nxt.he_dy        = $signed({1'b0, hand_y}) - $signed({1'b0, elbow_y});
    frm_nxt.es_dy        = $signed({1'b0, elbow_y}) - $signed({1'b0, shoulder_y});
    frm_nxt.se_dx        = $signed({1'b0, shoulder_x}) - $signed({1'b0, elbow_x});
  end

  always_comb begin
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (down_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      frm_r <= frm_nxt;
    end
  end

  assign frm_valid = valid_r;
  assign frm       = frm_r;

endmodule

FILE: hw/rtl/apd_window.sv
// Window stage of the arm pose hold detector: history rings, running sums,
// threshold tests, hold counter and the result register. Depends on apd_pkg.
module apd_window #(
  parameter int unsigned WINDOW = apd_pkg::WINDOW_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            frm_valid,
  input  apd_pkg::frame_t frm,
  input  apd_pkg::cfg_t   cfg,
  output logic            down_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            detected
);
  import apd_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = DELTA_W + CNT_W;
  localparam int unsigned PROD_W = DELTA_W + CNT_W + 1;
  localparam logic [CNT_W-1:0]  FILL_FULL = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  logic signed [DELTA_W-1:0] hist_r [4][WINDOW];
  logic signed [SUM_W-1:0]   sum_r [4];
  logic signed [SUM_W-1:0]   sum_nxt [4];
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [HOLD_W-1:0]         hold_r, hold_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      det_r, det_nxt;

  logic signed [DELTA_W-1:0] d [4];
  logic signed [PROD_W-1:0]  n_ext;
  logic signed [PROD_W-1:0]  lim_dx, lim_dy, lim_es_dy, lim_es_dx;
  logic signed [PROD_W-1:0]  s_ext [4];
  logic                      full, qual, adv, upd;

  assign down_ready = !out_valid_r || out_ready;
  assign adv        = frm_valid && down_ready;
  // Invalid frames leave the window state (sums, fill, slot, hold, rings) alone.
  assign upd        = adv && frm.joints_valid;

  assign d[0] = frm.he_dx;
  assign d[1] = frm.he_dy;
  assign d[2] = frm.es_dy;
  assign d[3] = frm.se_dx;

  assign full     = fill_r == FILL_FULL;
  assign fill_nxt = full ? fill_r : fill_r + 1'b1;
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_nxt[k] = sum_r[k] + {{(SUM_W-DELTA_W){d[k][DELTA_W-1]}}, d[k]};
      if (full) begin
        sum_nxt[k] = sum_nxt[k]
                   - {{(SUM_W-DELTA_W){hist_r[k][slot_r][DELTA_W-1]}}, hist_r[k][slot_r]};
      end
      s_ext[k] = {{(PROD_W-SUM_W){sum_nxt[k][SUM_W-1]}}, sum_nxt[k]};
    end
  end

  // Averages are compared as sum against threshold times entry count.
  always_comb begin
    n_ext     = $signed({{(PROD_W-CNT_W){1'b0}}, fill_nxt});
    lim_dx    = $signed({{(PROD_W-PIX_W){1'b0}}, cfg.he_dx_max}) * n_ext;
    lim_dy    = $signed({{(PROD_W-DELTA_W){cfg.he_dy_min[DELTA_W-1]}}, cfg.he_dy_min})
              * n_ext;
    lim_es_dy = $signed({{(PROD_W-DELTA_W){cfg.es_dy_max[DELTA_W-1]}}, cfg.es_dy_max})
              * n_ext;
    lim_es_dx = $signed({{(PROD_W-DELTA_W){cfg.es_dx_min[DELTA_W-1]}}, cfg.es_dx_min})
              * n_ext;
    qual = (s_ext[0] < lim_dx) && (s_ext[1] > lim_dy) && (s_ext[2] < lim_es_dy)
        && (s_ext[3] > lim_es_dx) && frm.depth_ok;
  end

  always_comb begin
    if (!qual) begin
      hold_nxt = '0;
    end else if (hold_r == HOLD_MAX) begin
      hold_nxt = hold_r;
    end else begin
      hold_nxt = hold_r + 1'b1;
    end
    det_nxt = frm.joints_valid && qual && (hold_nxt > cfg.hold_frames);
  end

  always_comb begin
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      slot_r      <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (upd) begin
        fill_r <= fill_nxt;
        slot_r <= slot_nxt;
        hold_r <= hold_nxt;
        for (int k = 0; k < 4; k++) begin
          sum_r[k] <= sum_nxt[k];
        end
      end
    end
  end

  // Ring entries are read only once the window is full, so every entry read
  // has been written first and the rings need no reset.
  always_ff @(posedge clk) begin
    if (upd) begin
      for (int k = 0; k < 4; k++) begin
        hist_r[k][slot_r] <= d[k];
      end
    end
    if (adv) begin
      det_r <= det_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign detected  = det_r;

endmodule

FILE: hw/rtl/arm_pose_hold_detector.sv
// Top level of the arm pose hold detector: stream ports, configuration
// registers and the two processing stages. Depends on apd_pkg, apd_delta
// and apd_window.

// One result comes out for every frame taken in, through the delta register
// and then the result register. A new frame can be taken in every cycle
// while the output side is not stalled: with running sums and one ring write
// per frame, the only loop is the registered window state (sums, fill count,
// ring slot, hold counter). Frames with joints_valid low leave the window
// state untouched and report no detection. The average over a partly filled
// window covers the frames held so far. The user writes configuration over
// the APB-style port only while no frame is in flight; the block does not
// enforce this. There is no clearing pass after reset.
module arm_pose_hold_detector #(
  parameter int unsigned WINDOW = apd_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] shoulder_x, [19:10] shoulder_y, [29:20] elbow_x, [39:30] elbow_y,
  // [49:40] hand_x, [59:50] hand_y, [72:60] hand_depth, [79:73] zero
  input  logic [79:0] in_tdata,
  // [0] joints_valid
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] detected, [7:1] zero
  output logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import apd_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     down_ready;
  logic     frm_valid;
  frame_t   frm;
  logic     detected;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.he_dx_max   <= RST_HE_DX_MAX;
      cfg_r.he_dy_min   <= RST_HE_DY_MIN;
      cfg_r.es_dy_max   <= RST_ES_DY_MAX;
      cfg_r.es_dx_min   <= RST_ES_DX_MIN;
      cfg_r.depth_min   <= RST_DEPTH_MIN;
      cfg_r.hold_frames <= RST_HOLD;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HE_DX_MAX: cfg_r.he_dx_max   <= cfg_pwdata[PIX_W-1:0];
        REG_HE_DY_MIN: cfg_r.he_dy_min   <= cfg_pwdata[DELTA_W-1:0];
        REG_ES_DY_MAX: cfg_r.es_dy_max   <= cfg_pwdata[DELTA_W-1:0];
        REG_ES_DX_MIN: cfg_r.es_dx_min   <= cfg_pwdata[DELTA_W-1:0];
        REG_DEPTH_MIN: cfg_r.depth_min   <= cfg_pwdata[DEPTH_W-1:0];
        REG_HOLD:      cfg_r.hold_frames <= cfg_pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Signed thresholds read back sign-extended.
  always_comb begin
    case (reg_idx)
      REG_HE_DX_MAX: cfg_prdata = {{(32-PIX_W){1'b0}}, cfg_r.he_dx_max};
      REG_HE_DY_MIN: cfg_prdata = {{(32-DELTA_W){cfg_r.he_dy_min[DELTA_W-1]}},
                                   cfg_r.he_dy_min};
      REG_ES_DY_MAX: cfg_prdata = {{(32-DELTA_W){cfg_r.es_dy_max[DELTA_W-1]}},
                                   cfg_r.es_dy_max};
      REG_ES_DX_MIN: cfg_prdata = {{(32-DELTA_W){cfg_r.es_dx_min[DELTA_W-1]}},
                                   cfg_r.es_dx_min};
      REG_DEPTH_MIN: cfg_prdata = {{(32-DEPTH_W){1'b0}}, cfg_r.depth_min};
      REG_HOLD:      cfg_prdata = {{(32-HOLD_W){1'b0}}, cfg_r.hold_frames};
      default:       cfg_prdata = '0;
    endcase
  end

  apd_delta u_delta (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .joints_valid (in_tuser),
    .shoulder_x   (in_tdata[9:0]),
    .shoulder_y   (in_tdata[19:10]),
    .elbow_x      (in_tdata[29:20]),
    .elbow_y      (in_tdata[39:30]),
    .hand_x       (in_tdata[49:40]),
    .hand_y       (in_tdata[59:50]),
    .hand_depth   (in_tdata[72:60]),
    .depth_min    (cfg_r.depth_min),
    .down_ready   (down_ready),
    .frm_valid    (frm_valid),
    .frm          (frm)
  );

  apd_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .frm_valid  (frm_valid),
    .frm        (frm),
    .cfg        (cfg_r),
    .down_ready (down_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .detected   (detected)
  );

  assign out_tdata = {7'd0, detected};

endmodule

FILE: hw/rtl/apd_checker.sv
// Port-level checks for the arm pose hold detector, bound to the top level.
// Depends only on the top level's ports.
module apd_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A result waiting on the output side holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A free output side never stalls the input side.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is free");

  // Only the detection bit of a result carries data.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind arm_pose_hold_detector apd_port_checks u_apd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
